// File: sv/tlpt_pkg.sv
// shared types, constants and command/status structs for the page table manager
package tlpt_pkg;

    localparam int DIR_ENTRIES   = 16;
    localparam int TABLE_ENTRIES = 256;
    localparam int FRAME_BITS    = 20;
    localparam int OFFSET_BITS   = 12;
    localparam int DIR_BITS      = $clog2(DIR_ENTRIES);
    localparam int TAB_BITS      = $clog2(TABLE_ENTRIES);
    localparam int ENTRY_BITS    = DIR_BITS + TAB_BITS;
    localparam int ENTRY_W       = FRAME_BITS + 1;

    typedef enum logic [1:0] {
        MODE_TRANSLATE = 2'd0,
        MODE_MAP       = 2'd1,
        MODE_UNMAP     = 2'd2,
        MODE_NOP       = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_MAPPED = 2'd1,
        ST_ALREADY    = 2'd2,
        ST_NO_FRAME   = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [23:0] virt_addr;
        logic [19:0] phys_frame;
        logic [19:0] spare_frame;
        logic        spare_valid;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] phys_addr;
        logic        spare_used;
        logic        freed_valid;
        logic [19:0] freed_frame;
        logic        flush_needed;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request
        logic rd;         // read page entry of request
        logic wr_map;     // write mapped entry
        logic wr_clr;     // clear entry of request
        logic sweep_clr;  // clear entry at sweep index
        logic sweep_rd;   // read entry at sweep index
        logic sweep_rst;  // sweep index to zero
        logic dir_set;    // create directory entry
        logic dir_clr;    // release directory entry
        logic emit;       // drive result
        logic [1:0] status;
        logic used;
        logic freed;
        logic flush;
        logic paddr_en;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] mode;
        logic dir_hit;
        logic pe_hit;
        logic spare_ok;
        logic sweep_last;
        logic sweep_hit;   // registered sweep read found a present entry
    } sts_t;

endpackage

// File: sv/tlpt_datapath.sv
// datapath: request register, directory, page entry memory and sweep counter
module tlpt_datapath import tlpt_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  ctl_t ctl,
    output sts_t sts,
    output rsp_t rsp
);

    req_t req_reg;
    logic [DIR_ENTRIES-1:0] dir_present_reg;
    logic [FRAME_BITS-1:0]  dir_frame_mem [DIR_ENTRIES];
    logic [ENTRY_W-1:0]     pe_mem [DIR_ENTRIES*TABLE_ENTRIES];
    logic [ENTRY_W-1:0]     rd_data_reg;
    logic [TAB_BITS-1:0]    sweep_reg;
    logic                   rd_sweep_reg;
    logic [DIR_BITS-1:0]    d;
    logic [TAB_BITS-1:0]    t;
    logic [ENTRY_BITS-1:0]  wr_addr;
    logic [ENTRY_BITS-1:0]  rd_addr;
    logic [ENTRY_W-1:0]     wr_data;
    logic                   wr_en;
    logic                   rd_en;

    assign t = req_reg.virt_addr[OFFSET_BITS +: TAB_BITS];
    assign d = req_reg.virt_addr[OFFSET_BITS+TAB_BITS +: DIR_BITS];

    always_ff @(posedge clk) begin
        if (ctl.load) begin
            req_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            dir_present_reg <= '0;
            sweep_reg       <= '0;
        end else begin
            if (ctl.dir_set) begin
                dir_present_reg[d] <= 1'b1;
            end else if (ctl.dir_clr) begin
                dir_present_reg[d] <= 1'b0;
            end
            if (ctl.sweep_rst) begin
                sweep_reg <= '0;
            end else if (ctl.sweep_clr || ctl.sweep_rd) begin
                sweep_reg <= sweep_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (ctl.dir_set) begin
            dir_frame_mem[d] <= req_reg.spare_frame;
        end
    end

    // single write port, single registered read port
    always_comb begin
        wr_en   = ctl.wr_map || ctl.wr_clr || ctl.sweep_clr;
        wr_addr = {d, t};
        wr_data = '0;
        if (ctl.sweep_clr) begin
            wr_addr = {d, sweep_reg};
        end else if (ctl.wr_map) begin
            wr_data = {1'b1, req_reg.phys_frame};
        end
        rd_en   = ctl.rd || ctl.sweep_rd;
        rd_addr = ctl.sweep_rd ? {d, sweep_reg} : {d, t};
    end

    always_ff @(posedge clk) begin
        if (wr_en) begin
            pe_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg      <= pe_mem[rd_addr];
            rd_sweep_reg     <= ctl.sweep_rd;
        end
    end

    assign sts.mode       = req_reg.mode;
    assign sts.dir_hit    = dir_present_reg[d];
    assign sts.pe_hit     = rd_data_reg[ENTRY_W-1];
    assign sts.spare_ok   = req_reg.spare_valid;
    assign sts.sweep_last = (sweep_reg == TAB_BITS'(TABLE_ENTRIES-1));
    assign sts.sweep_hit  = rd_sweep_reg && rd_data_reg[ENTRY_W-1];

    always_comb begin
        rsp              = '0;
        rsp.status       = ctl.status;
        rsp.spare_used   = ctl.used;
        rsp.freed_valid  = ctl.freed;
        rsp.flush_needed = ctl.flush;
        if (ctl.freed) begin
            rsp.freed_frame = dir_frame_mem[d];
        end
        if (ctl.paddr_en) begin
            rsp.phys_addr = {rd_data_reg[FRAME_BITS-1:0],
                             req_reg.virt_addr[OFFSET_BITS-1:0]};
        end
    end

endmodule

// File: sv/tlpt_ctrl.sv
// controller state machine sequencing reads, writes and table sweeps
module tlpt_ctrl import tlpt_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output ctl_t ctl,
    output logic busy,
    output logic done
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_READ   = 7'b0000010,
        S_EVAL   = 7'b0000100,
        S_CLEAR  = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_SCANW  = 7'b0100000,
        S_FREE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   found_reg, found_next;
    logic   hadpe_reg, hadpe_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            found_reg <= 1'b0;
            hadpe_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            found_reg <= found_next;
            hadpe_reg <= hadpe_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb begin
        state_next = state_reg;
        found_next = found_reg;
        hadpe_next = hadpe_reg;
        ctl        = '0;
        done       = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    ctl.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                ctl.rd     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                state_next = S_IDLE;
                unique case (mode_t'(sts.mode))
                    MODE_TRANSLATE: begin
                        done = 1'b1;
                        if (sts.dir_hit && sts.pe_hit) begin
                            ctl.paddr_en = 1'b1;
                        end else begin
                            ctl.status = ST_NOT_MAPPED;
                        end
                    end
                    MODE_MAP: begin
                        if (sts.dir_hit) begin
                            done = 1'b1;
                            if (sts.pe_hit) begin
                                ctl.status = ST_ALREADY;
                            end else begin
                                ctl.wr_map = 1'b1;
                                ctl.flush  = 1'b1;
                            end
                        end else if (!sts.spare_ok) begin
                            done       = 1'b1;
                            ctl.status = ST_NO_FRAME;
                        end else begin
                            ctl.dir_set   = 1'b1;
                            ctl.sweep_rst = 1'b1;
                            state_next    = S_CLEAR;
                        end
                    end
                    MODE_UNMAP: begin
                        if (!sts.dir_hit) begin
                            done       = 1'b1;
                            ctl.status = ST_NOT_MAPPED;
                        end else begin
                            hadpe_next    = sts.pe_hit;
                            found_next    = 1'b0;
                            ctl.wr_clr    = 1'b1;
                            ctl.sweep_rst = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    MODE_NOP: begin
                        done = 1'b1;
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
            end
            S_CLEAR: begin
                ctl.sweep_clr = 1'b1;
                if (sts.sweep_last) begin
                    state_next = S_FREE;
                end
            end
            S_SCAN: begin
                ctl.sweep_rd = 1'b1;
                if (sts.sweep_hit) begin
                    found_next = 1'b1;
                end
                if (sts.sweep_last) begin
                    state_next = S_SCANW;
                end
            end
            S_SCANW: begin
                // last read lands here; finish unmap
                done        = 1'b1;
                state_next  = S_IDLE;
                ctl.flush   = 1'b1;
                ctl.status  = hadpe_reg ? ST_OK : ST_NOT_MAPPED;
                if (!(found_reg || sts.sweep_hit)) begin
                    ctl.freed   = 1'b1;
                    ctl.dir_clr = 1'b1;
                end
            end
            S_FREE: begin
                // write mapped entry after the table clear
                done       = 1'b1;
                ctl.wr_map = 1'b1;
                ctl.used   = 1'b1;
                ctl.flush  = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("result without active request");
    a_free_unmap: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.freed |-> (state_reg == S_SCANW)) else $error("free outside unmap");
    a_clear_then_map: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) && sts.sweep_last |=> (state_reg == S_FREE))
        else $error("clear not followed by map");

endmodule

// File: sv/two_level_page_table_manager_core.sv
// top level of the two-level page table manager
// Takes one request per transfer (start while busy low) and answers each with
// exactly one result, shown for one cycle under done; the receiver cannot
// stall. Translate, a map into an existing table, a failed map and an unmap of
// an absent table pass through a page entry memory read, then evaluate. A map
// that builds a new table clears it one entry a cycle, then maps the page.
// An unmap with its table present scans the table for live entries one entry
// a cycle. No reset pass is needed: the directory present bits reset at once
// and each table is cleared when built.
module two_level_page_table_manager_core import tlpt_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    ctl_t ctl;
    sts_t sts;

    // sequencing of each request
    tlpt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    // storage and result formation
    tlpt_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .ctl   (ctl),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

// File: sim/tb.sv
// testbench for the two-level page table manager: scoreboard class and stimulus
`timescale 1ns / 1ps

module tb;
    import tlpt_pkg::*;

    // scoreboard: shadow page table plus queue of pending responses
    class pt_scoreboard;
        bit          dir_live [DIR_ENTRIES];
        bit [19:0]   dir_frame [DIR_ENTRIES];
        bit          pte_live [DIR_ENTRIES*TABLE_ENTRIES];
        bit [19:0]   pte_frame [DIR_ENTRIES*TABLE_ENTRIES];
        rsp_t        pending_rsp [$];
        int          mismatches;
        int          responses;

        // apply one accepted request to the shadow table and queue its response
        function void note_request(req_t r);
            rsp_t o;
            int unsigned d, e, pg;
            bit any;
            o = '0;
            pg = r.virt_addr[23:OFFSET_BITS];
            d = (pg / TABLE_ENTRIES) % DIR_ENTRIES;
            e = d * TABLE_ENTRIES + pg % TABLE_ENTRIES;
            case (mode_t'(r.mode))
                MODE_TRANSLATE:
                    if (!dir_live[d] || !pte_live[e])
                        o.status = ST_NOT_MAPPED;
                    else
                        o.phys_addr = {pte_frame[e], r.virt_addr[11:0]};
                MODE_MAP:
                    if (dir_live[d]) begin
                        if (pte_live[e])
                            o.status = ST_ALREADY;
                        else
                        begin
                            pte_live[e] = 1;
                            pte_frame[e] = r.phys_frame;
                            o.flush_needed = 1;
                        end
                    end
                    else if (!r.spare_valid)
                        o.status = ST_NO_FRAME;
                    else
                    begin
                        dir_live[d] = 1;
                        dir_frame[d] = r.spare_frame;
                        for (int i = 0; i < TABLE_ENTRIES; i++)
                        begin
                            pte_live[d*TABLE_ENTRIES+i] = 0;
                            pte_frame[d*TABLE_ENTRIES+i] = '0;
                        end
                        pte_live[e] = 1;
                        pte_frame[e] = r.phys_frame;
                        o.spare_used = 1;
                        o.flush_needed = 1;
                    end
                MODE_UNMAP:
                    if (!dir_live[d])
                        o.status = ST_NOT_MAPPED;
                    else
                    begin
                        if (pte_live[e])
                        begin
                            pte_live[e] = 0;
                            pte_frame[e] = '0;
                        end
                        else
                            o.status = ST_NOT_MAPPED;
                        any = 0;
                        for (int i = 0; i < TABLE_ENTRIES; i++)
                            any |= pte_live[d*TABLE_ENTRIES+i];
                        if (!any)
                        begin
                            o.freed_valid = 1;
                            o.freed_frame = dir_frame[d];
                            dir_live[d] = 0;
                        end
                        o.flush_needed = 1;
                    end
                default: ;
            endcase
            pending_rsp.push_back(o);
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            responses++;
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %h", got);
                return;
            end
            want = pending_rsp.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"response %0d: expected st=%0d pa=%h used=%b fv=%b ff=%h",
                              " fl=%b, got st=%0d pa=%h used=%b fv=%b ff=%h fl=%b"},
                        responses, want.status, want.phys_addr, want.spare_used,
                        want.freed_valid, want.freed_frame, want.flush_needed,
                        got.status, got.phys_addr, got.spare_used,
                        got.freed_valid, got.freed_frame, got.flush_needed);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic done;
    rsp_t rsp;

    pt_scoreboard sb;
    int stall_cycles;
    int transfers_in;

    two_level_page_table_manager_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        clk = 0;
        #5;
        clk = 1;
        #5;
    end

    // monitor: request transfers, responses and the idle watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_request(req);
                transfers_in++;
            end
            if (done)
                sb.check_response(rsp);
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles > 5000)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // send one request; start stays up until the transfer happens
    task automatic send_req(input logic [1:0] m, input logic [23:0] va,
                            input logic [19:0] pf, input logic [19:0] sf,
                            input logic sv, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 14) : 0;
        repeat (gap) @(posedge clk);
        start <= 1;
        req <= '{mode: m, virt_addr: va, phys_frame: pf, spare_frame: sf,
                 spare_valid: sv};
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 0;
    endtask

    function automatic logic [23:0] make_va(int unsigned d, int unsigned t);
        return {d[3:0], t[7:0], 12'($urandom)};
    endfunction

    task automatic wait_drained();
        while (sb.pending_rsp.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        int unsigned d, t, r;
        logic [1:0] m;
        sb = new();
        start = 0;
        req = '0;
        stall_cycles = 0;
        transfers_in = 0;
        rst_n = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: faults on empty table, failed map, extremes, table release
        send_req(MODE_TRANSLATE, 24'h000000, '0, '0, 0, 0);
        send_req(MODE_UNMAP, 24'hFFFFFF, '0, '0, 0, 0);
        send_req(MODE_MAP, 24'hFFFFFF, 20'hFFFFF, 20'hFFFFF, 0, 0);
        send_req(MODE_MAP, 24'hFFFFFF, 20'hFFFFF, 20'hFFFFF, 1, 0);
        send_req(MODE_TRANSLATE, 24'hFFFFFF, '0, '0, 0, 0);
        send_req(MODE_MAP, 24'hFFFFFF, 20'h12345, 20'h00000, 1, 0);
        send_req(MODE_MAP, 24'hFFE000, 20'h00000, 20'h00000, 0, 0);
        send_req(MODE_TRANSLATE, 24'hFFE000, '0, '0, 0, 0);
        send_req(MODE_UNMAP, 24'hFFF000, '0, '0, 0, 0);
        send_req(MODE_UNMAP, 24'hFFF000, '0, '0, 0, 0);
        send_req(MODE_UNMAP, 24'hFFE123, '0, '0, 0, 0);
        send_req(MODE_TRANSLATE, 24'hFFE123, '0, '0, 0, 0);
        send_req(MODE_MAP, 24'h000ABC, 20'hAAAAA, 20'h55555, 1, 0);
        send_req(MODE_TRANSLATE, 24'h000ABC, 20'hFFFFF, 20'hFFFFF, 1, 0);
        send_req(MODE_NOP, 24'hFFFFFF, 20'hFFFFF, 20'hFFFFF, 1, 0);
        send_req(MODE_NOP, 24'h000000, '0, '0, 0, 0);
        send_req(MODE_UNMAP, 24'h000ABC, '0, '0, 0, 0);
        wait_drained();

        // random: few tables, small page set so maps, hits and releases recur
        for (int n = 0; n < 1350; n++)
        begin
            d = $urandom_range(0, 3) * 5;
            if ($urandom_range(0, 9) == 0)
                d = $urandom_range(0, DIR_ENTRIES - 1);
            t = $urandom_range(0, 3);
            if ($urandom_range(0, 7) == 0)
                t = $urandom_range(0, TABLE_ENTRIES - 1);
            r = $urandom_range(0, 99);
            m = r < 35 ? MODE_TRANSLATE : r < 68 ? MODE_MAP : r < 97 ? MODE_UNMAP : MODE_NOP;
            send_req(m, make_va(d, t), 20'($urandom), 20'($urandom),
                     $urandom_range(0, 5) != 0, n % 200 >= 40);
            if (n == 700)
                wait_drained();
        end

        wait_drained();
        repeat (TABLE_ENTRIES + 20) @(posedge clk);
        $display("sent %0d requests, checked %0d responses (translate, map, unmap, nop)",
                 transfers_in, sb.responses);
        if (sb.mismatches == 0 && sb.pending_rsp.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// File: two_level_page_table_manager_core.f
sv/tlpt_pkg.sv
sv/tlpt_datapath.sv
sv/tlpt_ctrl.sv
sv/two_level_page_table_manager_core.sv
sim/tb.sv
